[rtl/sorted_record_table_defines.svh]
// ---------------------------------------------------------------------------
// sorted_record_table_defines: assertion macros
// Shared property wrappers for the record table checker.
// ---------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_DEFINES_SVH
`define SORTED_RECORD_TABLE_DEFINES_SVH

// same-cycle implication, off during reset
`define SRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// what must hold in the cycle after reset
`define SRT_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

[rtl/srt_pkg.sv]
// ---------------------------------------------------------------------------
// srt_pkg: sorted record table package
// Types, codes and name helpers shared by the record table files.
// ---------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int NAME_BYTES_DEF = 20;
  localparam int NAME_MAX       = 20;
  localparam int NAME_W         = 8 * NAME_MAX;
  localparam int MAX_OUT        = 32;

  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  localparam int POS_W  = 5;
  localparam int AGE_W  = 8;
  localparam int PHONE_W = 31;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SORT   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [AGE_W-1:0]   age;
    logic [PHONE_W-1:0] phone;
  } record_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_MISS, S_FIND_RD, S_FIND_CMP, S_HIT, S_SHIFT_RD, S_SHIFT_WR,
    S_SORT_LD, S_SORT_TMP, S_SORT_RD, S_SORT_CMP, S_SORT_PUT, S_SORT_END,
    S_EMPTY, S_LIST_EMIT
  } state_t;

  // keeps bytes 0 .. nb-1; byte 0 sits in the top byte
  function automatic logic [NAME_W-1:0] name_mask(input int nb);
    logic [NAME_W-1:0] m;
    m = '0;
    for (int k = 0; k < NAME_MAX; k++) begin
      if (k < nb) m[NAME_W-1-8*k -: 8] = 8'hFF;
    end
    return m;
  endfunction

  // strcmp order on zero-padded names: {a > b, a == b}
  function automatic logic [1:0] name_cmp(input logic [NAME_W-1:0] a,
                                          input logic [NAME_W-1:0] b);
    logic [1:0] r;
    logic [7:0] x;
    logic [7:0] y;
    r = 2'b01;
    for (int k = NAME_MAX - 1; k >= 0; k--) begin
      x = a[NAME_W-1-8*k -: 8];
      y = b[NAME_W-1-8*k -: 8];
      if (x != y) r = {(x > y), 1'b0};
      else if (x == 8'd0) r = 2'b01;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sorted_record_table.sv]
// ---------------------------------------------------------------------------
// sorted_record_table: record table with insertion sort by name
// Holds up to CAPACITY records (name, age, phone) in one RAM.
// ---------------------------------------------------------------------------
// Usage: one request enters on in_valid/in_ready and carries an action and
// its operands. Results leave on out_valid/out_ready; every action gives one
// result except list, which gives one per record (up to 32, last set on the
// final one), and codes 5 to 7, which give none.
// Steps, paced by the RAM's registered read:
//   insert          writes the new record after the last one, unless full
//   lookup / remove read, then compare, each entry walked; remove then reads
//                   and rewrites each later entry one place toward the front
//   sort            shifts larger earlier records back to put each in place
//   list            reads, then emits, each record
// One request is worked on at a time; in_ready is high only in idle.
// A finished result sits in the output register while the next request is
// taken; the sequencer waits there only when it must emit again before the
// receiver has taken the pending result.
// Reset clears the record count and the output valid; the RAM is not cleared,
// entries at or above the count are never read.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_record_table #(
  parameter int CAPACITY   = srt_pkg::CAPACITY_DEF,
  parameter int NAME_BYTES = srt_pkg::NAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [srt_pkg::ACT_W-1:0]    action,
  input  logic [63:0]                  key_bytes_first,
  input  logic [63:0]                  key_bytes_middle,
  input  logic [31:0]                  key_bytes_final,
  input  logic [srt_pkg::AGE_W-1:0]    new_age,
  input  logic [srt_pkg::PHONE_W-1:0]  new_phone,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [srt_pkg::STAT_W-1:0]   status,
  output logic [63:0]                  rec_bytes_first,
  output logic [63:0]                  rec_bytes_middle,
  output logic [31:0]                  rec_bytes_final,
  output logic [srt_pkg::AGE_W-1:0]    rec_age,
  output logic [srt_pkg::PHONE_W-1:0]  rec_phone,
  output logic [srt_pkg::POS_W-1:0]    position,
  output logic                         last
);

  import srt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [NAME_W-1:0] KEEP = name_mask(NAME_BYTES);

  state_t state, state_next;

  logic [ACT_W-1:0]   act;
  logic [NAME_W-1:0]  key;
  logic [AGE_W-1:0]   nage;
  logic [PHONE_W-1:0] nphone;
  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      j;
  record_t            tmp;
  record_t            hit;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  record_t       ram_wdata, rdata;

  logic          emit;
  logic [STAT_W-1:0] e_status;
  record_t       e_rec;
  logic [AW-1:0] e_pos;
  logic          e_last;

  logic          accept, out_free, full;
  logic [1:0]    find_cmp, sort_cmp;
  logic [CW-1:0] idx_c;
  logic          idx_is_end, list_last;

  srt_ram #(.WIDTH($bits(record_t)), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign full       = (count >= CW'(CAPACITY));
  assign find_cmp   = name_cmp(rdata.name, key);
  assign sort_cmp   = name_cmp(rdata.name, tmp.name);
  assign idx_c      = CW'(idx);
  assign idx_is_end = (idx_c + CW'(1) == count);
  assign list_last  = idx_is_end || ((AW+1)'(idx) + (AW+1)'(1) == (AW+1)'(MAX_OUT));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (action)
            ACT_INSERT: state_next = S_INS;
            ACT_REMOVE, ACT_LOOKUP: state_next = (count == '0) ? S_MISS : S_FIND_RD;
            ACT_SORT: state_next = (count < CW'(2)) ? S_SORT_END : S_SORT_LD;
            ACT_LIST: state_next = (count == '0) ? S_EMPTY : S_FIND_RD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INS, S_MISS, S_SORT_END, S_EMPTY: if (out_free) state_next = S_IDLE;
      S_FIND_RD: state_next = (act == ACT_LIST) ? S_LIST_EMIT : S_FIND_CMP;
      S_FIND_CMP: begin
        if (find_cmp[0]) state_next = S_HIT;
        else if (idx_is_end) state_next = S_MISS;
        else state_next = S_FIND_RD;
      end
      S_HIT: begin
        if (out_free) begin
          if (act == ACT_REMOVE && !idx_is_end) state_next = S_SHIFT_RD;
          else state_next = S_IDLE;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (idx_c + CW'(2) < count) ? S_SHIFT_RD : S_IDLE;
      S_SORT_LD:  state_next = S_SORT_TMP;
      S_SORT_TMP: state_next = S_SORT_RD;
      S_SORT_RD:  state_next = S_SORT_CMP;
      S_SORT_CMP: begin
        if (sort_cmp[1] && j != AW'(1)) state_next = S_SORT_RD;
        else state_next = S_SORT_PUT;
      end
      S_SORT_PUT: state_next = (idx_c + CW'(1) < count) ? S_SORT_LD : S_SORT_END;
      S_LIST_EMIT: begin
        if (out_free) state_next = list_last ? S_IDLE : S_FIND_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM access and result selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = rdata;
    ram_re    = 1'b0;
    ram_raddr = idx;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_rec     = '0;
    e_pos     = '0;
    e_last    = 1'b1;
    unique case (state)
      S_INS: begin
        emit = out_free;
        if (full) begin
          e_status = ST_FULL;
        end else begin
          ram_we    = out_free;
          ram_waddr = AW'(count);
          ram_wdata = '{name: key, age: nage, phone: nphone};
          e_rec     = ram_wdata;
          e_pos     = AW'(count);
        end
      end
      S_MISS: begin
        emit     = out_free;
        e_status = ST_NOTFOUND;
      end
      S_EMPTY: begin
        emit     = out_free;
        e_status = ST_EMPTY;
      end
      S_SORT_END: emit = out_free;
      S_FIND_RD: ram_re = 1'b1;
      S_HIT: begin
        emit  = out_free;
        e_rec = hit;
        e_pos = idx;
      end
      S_LIST_EMIT: begin
        emit   = out_free;
        e_rec  = rdata;
        e_pos  = idx;
        e_last = list_last;
      end
      S_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx + AW'(1);
      end
      S_SHIFT_WR: ram_we = 1'b1;
      S_SORT_LD: ram_re = 1'b1;
      S_SORT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = j - AW'(1);
      end
      S_SORT_CMP: begin
        ram_we    = sort_cmp[1];
        ram_waddr = j;
      end
      S_SORT_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = tmp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == S_INS && out_free && !full) count <= count + CW'(1);
      if ((state == S_HIT && out_free && act == ACT_REMOVE && idx_is_end)
          || (state == S_SHIFT_WR && !(idx_c + CW'(2) < count)))
        count <= count - CW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act    <= action;
      key    <= {key_bytes_first, key_bytes_middle, key_bytes_final} & KEEP;
      nage   <= new_age;
      nphone <= new_phone;
      idx    <= (action == ACT_SORT) ? AW'(1) : '0;
    end
    unique case (state)
      S_FIND_CMP: begin
        if (find_cmp[0]) hit <= rdata;
        else idx <= idx + AW'(1);
      end
      S_LIST_EMIT: if (out_free) idx <= idx + AW'(1);
      S_SHIFT_WR:  idx <= idx + AW'(1);
      S_SORT_TMP: begin
        tmp <= rdata;
        j   <= idx;
      end
      S_SORT_CMP: if (sort_cmp[1]) j <= j - AW'(1);
      S_SORT_PUT: idx <= idx + AW'(1);
      default: ;
    endcase
    if (emit) begin
      status           <= e_status;
      rec_bytes_first  <= e_rec.name[NAME_W-1 -: 64];
      rec_bytes_middle <= e_rec.name[NAME_W-65 -: 64];
      rec_bytes_final  <= e_rec.name[31:0];
      rec_age          <= e_rec.age;
      rec_phone        <= e_rec.phone;
      position         <= POS_W'(e_pos);
      last             <= e_last;
    end
  end

endmodule

`default_nettype wire

[rtl/srt_ram.sv]
// ---------------------------------------------------------------------------
// srt_ram: generic synchronous RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/srt_checker.sv]
// ---------------------------------------------------------------------------
// srt_checker: port-level checks for the record table
// Watches the result channel and in_ready over time; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sorted_record_table_defines.svh"

module srt_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [srt_pkg::STAT_W-1:0]  status,
  input wire logic [srt_pkg::AGE_W-1:0]   rec_age,
  input wire logic [srt_pkg::POS_W-1:0]   position,
  input wire logic                        last
);

  import srt_pkg::*;

  `SRT_ASSERT_RST(a_rst_quiet, !out_valid && in_ready, "result valid or busy after reset")
  `SRT_ASSERT_IMPL(a_err_last, out_valid && status != ST_OK, last, "error result without last")
  `SRT_ASSERT_IMPL(a_err_zero, out_valid && status != ST_OK, position == '0 && rec_age == '0, "error result carries record data")
  `SRT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(last), "stalled result changed")

endmodule

bind sorted_record_table srt_checker u_srt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .rec_age   (rec_age),
  .position  (position),
  .last      (last)
);

`default_nettype wire
